// ===== rtl/kmca_pkg.sv =====
// ----------------------------------------------------------------------------
// kmca_pkg
// Shared widths, codes, control/status bundles and the square lookup table
// for the k-means color assignment and update block.
// ----------------------------------------------------------------------------
package kmca_pkg;

  localparam int unsigned NUM_REGS   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned DIST_W     = 18;
  localparam int unsigned IDX_OUT_W  = 3;
  localparam int unsigned CNT_OUT_W  = 17;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic {
    KIND_LABEL = 1'b0,
    KIND_MEAN  = 1'b1
  } kind_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // take a pixel, register its distances
    logic pick;        // register the nearest cluster
    logic label;       // load the label result, accumulate the pixel
    logic mean_start;  // start the dividers for the current cluster
    logic mean_out;    // load the mean result, write back, advance
  } kmca_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fin;         // captured pixel closes the pass
    logic cnt_zero;    // current cluster got no pixels
    logic div_done;    // dividers hold their quotients
    logic out_free;    // output register can take a result
    logic last_clu;    // current cluster is the last one
  } kmca_status_t;

  typedef logic [15:0] square_t;
  typedef square_t square_lut_t [256];

  function automatic square_lut_t build_square_lut();
    square_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = square_t'(i * i);
    end
    return lut;
  endfunction

  localparam square_lut_t SQUARE_LUT = build_square_lut();

endpackage

// ===== rtl/kmca_div.sv =====
// ----------------------------------------------------------------------------
// kmca_div
// Restoring divider, one quotient bit per cycle, with round half to even.
// The dividend is known to stay below 256 times the divisor.
// ----------------------------------------------------------------------------
module kmca_div #(
  parameter int unsigned SUM_W = 25,
  parameter int unsigned CNT_W = 17
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SUM_W-1:0]          dividend_i,
  input  logic [CNT_W-1:0]          divisor_i,
  output logic                      done_o,
  output logic [kmca_pkg::CH_W-1:0] quotient_o
);
  import kmca_pkg::*;

  localparam int unsigned DEN_W  = CNT_W + CH_W - 1;
  localparam int unsigned STEP_W = $clog2(CH_W);

  logic [SUM_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [CNT_W-1:0]  div_q;
  logic [CH_W-1:0]   quo_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic              fits;
  logic [SUM_W-1:0]  rem_sub;
  logic [CNT_W:0]    twice_rem;
  logic [CNT_W:0]    div_ext;
  logic              round_up;
  logic [CH_W:0]     quo_rnd;

  assign fits    = rem_q >= SUM_W'(den_q);
  assign rem_sub = rem_q - SUM_W'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == STEP_W'(CH_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      den_q <= {divisor_i, {(CH_W - 1){1'b0}}};
      div_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_sub;
      end
      quo_q <= {quo_q[CH_W-2:0], fits};
      den_q <= den_q >> 1;
    end
  end

  // Remainder is below the divisor here, so its low bits carry it all
  assign twice_rem  = {rem_q[CNT_W-1:0], 1'b0};
  assign div_ext    = {1'b0, div_q};
  assign round_up   = (twice_rem > div_ext) || ((twice_rem == div_ext) && quo_q[0]);
  assign quo_rnd    = {1'b0, quo_q} + (CH_W + 1)'(round_up);
  assign quotient_o = quo_rnd[CH_W] ? {CH_W{1'b1}} : quo_rnd[CH_W-1:0];
  assign done_o     = done_q;

endmodule

// ===== rtl/kmca_datapath.sv =====
// ----------------------------------------------------------------------------
// kmca_datapath
// Centroids, distance and nearest-cluster logic, per-cluster sums and counts,
// mean dividers and the output register.
// ----------------------------------------------------------------------------
module kmca_datapath #(
  parameter int unsigned CLUSTERS   = 5,
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  kmca_pkg::kmca_cmd_t             cmd_i,
  output kmca_pkg::kmca_status_t          status_o,
  input  logic [kmca_pkg::IN_DATA_W-1:0]  pix_data_i,
  input  logic                            pix_last_i,
  input  logic                            cfg_we_i,
  input  logic [kmca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmca_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [kmca_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                            out_kind_o,
  output logic                            out_last_o
);
  import kmca_pkg::*;

  localparam int unsigned IDX_W = (CLUSTERS > 1) ? $clog2(CLUSTERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SUM_W = CNT_W + CH_W;

  typedef struct packed {
    logic [2:0]           pad;
    logic                 empty_cluster;
    logic [CNT_OUT_W-1:0] member_count;
    logic [CH_W-1:0]      mean_blue;
    logic [CH_W-1:0]      mean_green;
    logic [CH_W-1:0]      mean_red;
    logic [IDX_OUT_W-1:0] cluster_index;
  } result_t;

  function automatic logic [DIST_W-1:0] color_dist(
    input logic [CH_W-1:0] pr, input logic [CH_W-1:0] pg, input logic [CH_W-1:0] pb,
    input logic [CH_W-1:0] cr, input logic [CH_W-1:0] cg, input logic [CH_W-1:0] cb
  );
    logic [CH_W-1:0] ar;
    logic [CH_W-1:0] ag;
    logic [CH_W-1:0] ab;
    ar = (pr >= cr) ? pr - cr : cr - pr;
    ag = (pg >= cg) ? pg - cg : cg - pg;
    ab = (pb >= cb) ? pb - cb : cb - pb;
    return DIST_W'(SQUARE_LUT[ar]) + DIST_W'(SQUARE_LUT[ag]) + DIST_W'(SQUARE_LUT[ab]);
  endfunction

  logic [CFG_DATA_W-1:0] cent_q  [CLUSTERS];
  logic [SUM_W-1:0]      sum_r_q [CLUSTERS];
  logic [SUM_W-1:0]      sum_g_q [CLUSTERS];
  logic [SUM_W-1:0]      sum_b_q [CLUSTERS];
  logic [CNT_W-1:0]      cnt_q   [CLUSTERS];
  logic [CNT_W-1:0]      total_q;
  logic [DIST_W-1:0]     dist_q  [CLUSTERS];
  logic [DIST_W-1:0]     dist_d  [CLUSTERS];

  logic [CH_W-1:0]       pix_r_q;
  logic [CH_W-1:0]       pix_g_q;
  logic [CH_W-1:0]       pix_b_q;
  logic                  fin_q;
  logic [IDX_W-1:0]      best_q;
  logic [IDX_W-1:0]      best_d;
  logic [IDX_W-1:0]      clu_q;

  logic                  out_valid_q;
  result_t               out_data_q;
  kind_e                 out_kind_q;
  logic                  out_last_q;

  logic [CFG_DATA_W-1:0] sel_cent;
  logic [CNT_W-1:0]      sel_cnt;
  logic                  cnt_zero;
  logic                  last_clu;
  logic                  accum_ok;
  logic [2:0]            div_done;
  logic [CH_W-1:0]       q_r;
  logic [CH_W-1:0]       q_g;
  logic [CH_W-1:0]       q_b;
  result_t               label_res;
  result_t               mean_res;

  // Distances straight from the input bus, registered at capture
  always_comb begin
    for (int j = 0; j < CLUSTERS; j++) begin
      dist_d[j] = color_dist(pix_data_i[7:0], pix_data_i[15:8], pix_data_i[23:16],
                             cent_q[j][23:16], cent_q[j][15:8], cent_q[j][7:0]);
    end
  end

  // Nearest cluster, strict compare keeps the lowest index on ties
  always_comb begin
    logic [DIST_W-1:0] best_dist;
    best_d    = '0;
    best_dist = dist_q[0];
    for (int j = 1; j < CLUSTERS; j++) begin
      if (dist_q[j] < best_dist) begin
        best_d    = IDX_W'(j);
        best_dist = dist_q[j];
      end
    end
  end

  assign sel_cent = cent_q[clu_q];
  assign sel_cnt  = cnt_q[clu_q];
  assign cnt_zero = (sel_cnt == '0);
  assign last_clu = (clu_q == IDX_W'(CLUSTERS - 1));
  assign accum_ok = (total_q < CNT_W'(MAX_PIXELS));

  kmca_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_r (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mean_start), .dividend_i(sum_r_q[clu_q]), .divisor_i(sel_cnt),
    .done_o(div_done[0]), .quotient_o(q_r)
  );

  kmca_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_g (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mean_start), .dividend_i(sum_g_q[clu_q]), .divisor_i(sel_cnt),
    .done_o(div_done[1]), .quotient_o(q_g)
  );

  kmca_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div_b (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mean_start), .dividend_i(sum_b_q[clu_q]), .divisor_i(sel_cnt),
    .done_o(div_done[2]), .quotient_o(q_b)
  );

  // Centroid registers: configuration writes and mean write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CLUSTERS; j++) begin
        cent_q[j] <= '0;
      end
    end else if (cfg_we_i && (32'(cfg_index_i) < NUM_REGS) && (32'(cfg_index_i) < CLUSTERS)) begin
      cent_q[cfg_index_i[IDX_W-1:0]] <= cfg_data_i;
    end else if (cmd_i.mean_out && !cnt_zero) begin
      cent_q[clu_q] <= {q_r, q_g, q_b};
    end
  end

  // Per-cluster accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < CLUSTERS; j++) begin
        sum_r_q[j] <= '0;
        sum_g_q[j] <= '0;
        sum_b_q[j] <= '0;
        cnt_q[j]   <= '0;
      end
      total_q <= '0;
    end else if (cmd_i.label && accum_ok) begin
      sum_r_q[best_q] <= sum_r_q[best_q] + SUM_W'(pix_r_q);
      sum_g_q[best_q] <= sum_g_q[best_q] + SUM_W'(pix_g_q);
      sum_b_q[best_q] <= sum_b_q[best_q] + SUM_W'(pix_b_q);
      cnt_q[best_q]   <= cnt_q[best_q] + 1'b1;
      total_q         <= total_q + 1'b1;
    end else if (cmd_i.mean_out && last_clu) begin
      for (int j = 0; j < CLUSTERS; j++) begin
        sum_r_q[j] <= '0;
        sum_g_q[j] <= '0;
        sum_b_q[j] <= '0;
        cnt_q[j]   <= '0;
      end
      total_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_r_q <= pix_data_i[7:0];
      pix_g_q <= pix_data_i[15:8];
      pix_b_q <= pix_data_i[23:16];
      fin_q   <= pix_last_i;
      for (int j = 0; j < CLUSTERS; j++) begin
        dist_q[j] <= dist_d[j];
      end
    end
    if (cmd_i.pick) begin
      best_q <= best_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clu_q <= '0;
    end else if (cmd_i.mean_out) begin
      clu_q <= last_clu ? '0 : clu_q + 1'b1;
    end
  end

  always_comb begin
    label_res               = '0;
    label_res.cluster_index = IDX_OUT_W'(best_q);
  end

  always_comb begin
    mean_res               = '0;
    mean_res.cluster_index = IDX_OUT_W'(clu_q);
    if (cnt_zero) begin
      mean_res.mean_red      = sel_cent[23:16];
      mean_res.mean_green    = sel_cent[15:8];
      mean_res.mean_blue     = sel_cent[7:0];
      mean_res.empty_cluster = 1'b1;
    end else begin
      mean_res.mean_red     = q_r;
      mean_res.mean_green   = q_g;
      mean_res.mean_blue    = q_b;
      mean_res.member_count = CNT_OUT_W'(sel_cnt);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.label || cmd_i.mean_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.label) begin
      out_data_q <= label_res;
      out_kind_q <= KIND_LABEL;
      out_last_q <= !fin_q;
    end else if (cmd_i.mean_out) begin
      out_data_q <= mean_res;
      out_kind_q <= KIND_MEAN;
      out_last_q <= last_clu;
    end
  end

  assign status_o.fin      = fin_q;
  assign status_o.cnt_zero = cnt_zero;
  assign status_o.div_done = &div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last_clu = last_clu;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/kmca_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmca_ctrl
// Sequencer for one pixel (capture, pick, label) and for the mean pass
// (start dividers, wait, emit) over every cluster.
// ----------------------------------------------------------------------------
module kmca_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  kmca_pkg::kmca_status_t status_i,
  output kmca_pkg::kmca_cmd_t    cmd_o
);
  import kmca_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_LABEL,
    S_MEAN_START,
    S_MEAN_DIV,
    S_MEAN_OUT
  } state_e;

  state_e state_q;
  state_e state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_PICK;
        end
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_LABEL;
      end
      S_LABEL: begin
        if (status_i.out_free) begin
          cmd_o.label = 1'b1;
          state_d     = status_i.fin ? S_MEAN_START : S_IDLE;
        end
      end
      S_MEAN_START: begin
        cmd_o.mean_start = 1'b1;
        state_d          = status_i.cnt_zero ? S_MEAN_OUT : S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        if (status_i.div_done) begin
          state_d = S_MEAN_OUT;
        end
      end
      S_MEAN_OUT: begin
        if (status_i.out_free) begin
          cmd_o.mean_out = 1'b1;
          state_d        = status_i.last_clu ? S_IDLE : S_MEAN_START;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

endmodule

// ===== rtl/kmeans_color_assign_update.sv =====
// ----------------------------------------------------------------------------
// kmeans_color_assign_update
// One k-means assignment and update pass over a stream of RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_axis channel, tlast marking the last pixel of a pass.
//   Each pixel yields a label request on m_axis (tuser = 0) with the nearest
//   centroid, lowest index on a tie; up to MAX_PIXELS per pass join its sums.
//   After the last pixel the block sends one mean request per cluster
//   (tuser = 1), in index order, writes each mean back as the new centroid
//   and clears the sums. An empty cluster reports its old centroid.
//   m_axis tlast marks the final request caused by one pixel.
//   Centroids are loaded through the cfg write port while the block is idle.
// Sequence:
//   A pixel goes through capture with distances, nearest pick, label load;
//   the next pixel is taken right after. Per non-empty cluster the mean pass
//   starts the bit-serial dividers, waits for them and emits the mean; an
//   empty one goes straight from start to emit. No input is taken meanwhile.
// Reset clears centroids, sums and counts. When the receiver stalls, the
// output register holds its request and the block waits before the next load;
// a pixel can still be captured while a label waits to be taken.
// ----------------------------------------------------------------------------
module kmeans_color_assign_update #(
  parameter int unsigned CLUSTERS   = 5,
  parameter int unsigned MAX_PIXELS = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] pixel_red, [15:8] pixel_green, [23:16] pixel_blue
  input  logic [kmca_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                            s_axis_tlast,   // final_pixel
  // Results
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] cluster_index, [10:3] mean_red, [18:11] mean_green,
  // [26:19] mean_blue, [43:27] member_count, [44] empty_cluster, [47:45] zero
  output logic [kmca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,   // [0] kind
  output logic                            m_axis_tlast,   // end_of_run
  // Centroid writes
  input  logic                            cfg_we_i,
  input  logic [kmca_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmca_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kmca_pkg::*;

  kmca_cmd_t    cmd;
  kmca_status_t status;

  // Sequence pixel and mean work
  kmca_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Hold centroids, sums, dividers and the output register
  kmca_datapath #(
    .CLUSTERS   (CLUSTERS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .status_o    (status),
    .pix_data_i  (s_axis_tdata),
    .pix_last_i  (s_axis_tlast),
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/kmca_checker.sv =====
// ----------------------------------------------------------------------------
// kmca_checker
// Port-level checks for the k-means block, bound to the top level.
// ----------------------------------------------------------------------------
module kmca_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kmca_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);

  // A captured pixel keeps the input closed for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a pixel is in work");

  // A pending request that is not the last of its run means a pass is open
  a_pass_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open during a mean pass");

  // Mean requests flag empty exactly when no member was counted
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[44] == (m_axis_tdata[43:27] == 17'd0)))
    else $error("empty flag disagrees with member count");

  // Stalled request holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind kmeans_color_assign_update kmca_checker u_kmca_checker (.*);

// ===== dv/tb_kmeans_color_assign_update.sv =====
// ----------------------------------------------------------------------------
// tb_kmeans_color_assign_update
// Self-checking bench for the k-means color assignment and update block.
// Pixels go in on the s_axis side with random gaps. A local copy of the
// centroids and per-cluster sums predicts every label and every cluster mean.
// Results taken on m_axis under random backpressure are checked, field by
// field and in order, against that prediction. A directed table opens the
// run. Random passes follow with different centroid settings, and a short
// pass with all centroids equal ends the run.
// ----------------------------------------------------------------------------
module tb_kmeans_color_assign_update;
  import kmca_pkg::*;

  localparam int          CLUSTERS       = 5;
  localparam int unsigned MAX_PIXELS     = 65536;
  localparam int          RANDOM_PASSES  = 8;
  localparam int          CLOSE_PASS     = 8;
  localparam int          HOLDOFF_CYCLES = 200;
  localparam int          TAIL_CYCLES    = 100;
  localparam int          NO_LABEL       = -1;
  localparam int          N_DIRECTED     = 19;
  localparam int          MAX_REPORTS    = 10;

  // One expected or observed request on m_axis
  typedef struct packed {
    kind_e       kind;
    logic [2:0]  idx;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] count;
    logic        empty;
    logic        eor;
    logic [2:0]  pad;
  } km_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_PIXEL
  } row_e;

  // Directed row: a centroid write (idx, data) or a pixel (data = r,g,b)
  typedef struct {
    row_e        op;
    logic [2:0]  idx;
    logic [23:0] data;
    logic        fin;
    int          label;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Predicted block state
  logic [23:0] ctr_rgb [CLUSTERS];
  logic [23:0] acc_r   [CLUSTERS];
  logic [23:0] acc_g   [CLUSTERS];
  logic [23:0] acc_b   [CLUSTERS];
  logic [16:0] acc_n   [CLUSTERS];
  int unsigned pass_pixels;

  km_result_t pending_results [$];
  int         errors = 0;

  // Idling control shared by the pixel source and the result sink
  logic idle_on      = 1'b1;
  int   holdoff_req  = 0;
  int   holdoff_seen;
  int   sink_wait;

  stim_row_t directed_rows [N_DIRECTED];

  kmeans_color_assign_update #(
    .CLUSTERS  (CLUSTERS),
    .MAX_PIXELS(MAX_PIXELS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // [7:0] red, [15:8] green, [23:16] blue
    .s_axis_tlast (s_axis_tlast),   // final_pixel
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // [2:0] idx, [10:3] r, [18:11] g, [26:19] b,
                                    // [43:27] count, [44] empty, [47:45] zero
    .m_axis_tuser (m_axis_tuser),   // [0] kind
    .m_axis_tlast (m_axis_tlast),   // end_of_run
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Gap length for either side: mostly none, mostly short when present
  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] round_mean(logic [23:0] total, logic [16:0] n);
    int unsigned q, rem;
    q   = total / n;
    rem = total % n;
    // Round half to even
    if (2 * rem > n || (2 * rem == n && q[0])) q++;
    return (q > 255) ? 8'hFF : q[7:0];
  endfunction

  function automatic logic [7:0] jitter(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  task automatic clear_pass();
    for (int j = 0; j < CLUSTERS; j++) begin
      acc_r[j] = '0;
      acc_g[j] = '0;
      acc_b[j] = '0;
      acc_n[j] = '0;
    end
    pass_pixels = 0;
  endtask

  // Append one expectation behind the ones still pending
  task automatic queue_result(input km_result_t r);
    pending_results = {pending_results, r};
  endtask

  // Nearest centroid, accumulation and, on the final pixel, the mean pass.
  // A typed label, where given, replaces the computed one in the expectation.
  task automatic predict_pixel(input logic [23:0] rgb, input logic fin,
                               input int typed_label);
    int         best, best_d, d, dr, dg, db;
    km_result_t res;
    best   = 0;
    best_d = 0;
    for (int j = 0; j < CLUSTERS; j++) begin
      dr = int'(rgb[23:16]) - int'(ctr_rgb[j][23:16]);
      dg = int'(rgb[15:8])  - int'(ctr_rgb[j][15:8]);
      db = int'(rgb[7:0])   - int'(ctr_rgb[j][7:0]);
      d  = dr * dr + dg * dg + db * db;
      // Strict compare keeps the lowest index on a tie
      if (j == 0 || d < best_d) begin
        best   = j;
        best_d = d;
      end
    end
    // Drop pixels beyond the per-pass limit from the sums
    if (pass_pixels < MAX_PIXELS) begin
      acc_r[best] += rgb[23:16];
      acc_g[best] += rgb[15:8];
      acc_b[best] += rgb[7:0];
      acc_n[best] += 17'd1;
      pass_pixels++;
    end
    res      = '0;
    res.kind = KIND_LABEL;
    res.idx  = (typed_label >= 0) ? 3'(typed_label) : 3'(best);
    res.eor  = !fin;
    queue_result(res);
    if (fin) begin
      for (int j = 0; j < CLUSTERS; j++) begin
        res       = '0;
        res.kind  = KIND_MEAN;
        res.idx   = 3'(j);
        res.count = acc_n[j];
        res.eor   = (j == CLUSTERS - 1);
        if (acc_n[j] == 0) begin
          // Empty cluster reports and keeps its old centroid
          res.empty = 1'b1;
          {res.red, res.green, res.blue} = ctr_rgb[j];
        end else begin
          res.red    = round_mean(acc_r[j], acc_n[j]);
          res.green  = round_mean(acc_g[j], acc_n[j]);
          res.blue   = round_mean(acc_b[j], acc_n[j]);
          ctr_rgb[j] = {res.red, res.green, res.blue};
        end
        queue_result(res);
      end
      clear_pass();
    end
  endtask

  // Offer one pixel after a random gap; predict on acceptance
  task automatic send_pixel(input logic [23:0] rgb, input logic fin,
                            input int typed_label);
    int gap;
    gap = pick_gap();
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rgb[7:0], rgb[15:8], rgb[23:16]};
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(rgb, fin, typed_label);
  endtask

  // Hold the source until every expected request has been taken
  task automatic drain();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the block idle; indexes past the last cluster are ignored
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    if (idx < NUM_REGS && idx < CLUSTERS) ctr_rgb[idx] = value;
    @(posedge clk_i);
  endtask

  // Result sink: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    int gap;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
      holdoff_seen  <= 0;
    end else if (holdoff_seen != holdoff_req) begin
      holdoff_seen  <= holdoff_req;
      sink_wait     <= HOLDOFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait     <= sink_wait - 1;
      m_axis_tready <= 1'b0;
    end else begin
      gap = pick_gap();
      if (gap > 0) begin
        sink_wait     <= gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every taken request with the oldest expectation
  always @(posedge clk_i) begin
    km_result_t seen, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.kind  = kind_e'(m_axis_tuser);
      seen.idx   = m_axis_tdata[2:0];
      seen.red   = m_axis_tdata[10:3];
      seen.green = m_axis_tdata[18:11];
      seen.blue  = m_axis_tdata[26:19];
      seen.count = m_axis_tdata[43:27];
      seen.empty = m_axis_tdata[44];
      seen.pad   = m_axis_tdata[47:45];
      seen.eor   = m_axis_tlast;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected request: kind=%0d idx=%0d rgb=%0d,%0d,%0d n=%0d",
                   seen.kind, seen.idx, seen.red, seen.green, seen.blue, seen.count);
      end else begin
        want = pending_results.pop_front();
        if (seen != want) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("mismatch want kind=%0d idx=%0d rgb=%0d,%0d,%0d n=%0d e=%0b l=%0b p=%0d",
                     want.kind, want.idx, want.red, want.green, want.blue,
                     want.count, want.empty, want.eor, want.pad);
            $display("         got  kind=%0d idx=%0d rgb=%0d,%0d,%0d n=%0d e=%0b l=%0b p=%0d",
                     seen.kind, seen.idx, seen.red, seen.green, seen.blue,
                     seen.count, seen.empty, seen.eor, seen.pad);
          end
        end
      end
    end
  end

  initial begin
    int          n;
    logic [23:0] v, rgb;
    // After reset every centroid is zero, so the first labels all tie to 0.
    // Then each centroid goes to a corner of the color cube; indexes past the last
    // register must be ignored.
    directed_rows = '{
      '{ROW_PIXEL, 3'd0, 24'h000000, 1'b0, 0},
      '{ROW_PIXEL, 3'd0, 24'hFFFFFF, 1'b0, 0},
      '{ROW_PIXEL, 3'd0, 24'hFF00FF, 1'b1, 0},
      '{ROW_CFG,   3'd0, 24'h000000, 1'b0, NO_LABEL},
      '{ROW_CFG,   3'd1, 24'hFFFFFF, 1'b0, NO_LABEL},
      '{ROW_CFG,   3'd2, 24'hFF0000, 1'b0, NO_LABEL},
      '{ROW_CFG,   3'd3, 24'h00FF00, 1'b0, NO_LABEL},
      '{ROW_CFG,   3'd4, 24'h0000FF, 1'b0, NO_LABEL},
      '{ROW_CFG,   3'd5, 24'h123456, 1'b0, NO_LABEL},
      '{ROW_CFG,   3'd7, 24'hFFFFFF, 1'b0, NO_LABEL},
      '{ROW_PIXEL, 3'd0, 24'hFFFFFF, 1'b0, 1},
      '{ROW_PIXEL, 3'd0, 24'hFF0000, 1'b0, 2},
      '{ROW_PIXEL, 3'd0, 24'h00FF00, 1'b0, 3},
      '{ROW_PIXEL, 3'd0, 24'h0000FF, 1'b0, 4},
      '{ROW_PIXEL, 3'd0, 24'h000000, 1'b0, 0},
      // Equal distance to the red and green corners: lower index wins
      '{ROW_PIXEL, 3'd0, 24'h808000, 1'b0, 2},
      // Means of this pass hit exact halves: round to even
      '{ROW_PIXEL, 3'd0, 24'h010203, 1'b1, 0},
      '{ROW_CFG,   3'd6, 24'hABCDEF, 1'b0, NO_LABEL},
      // Single-pixel pass: four clusters stay empty and keep their centroid
      '{ROW_PIXEL, 3'd0, 24'h000000, 1'b1, NO_LABEL}
    };

    for (int j = 0; j < CLUSTERS; j++) ctr_rgb[j] = '0;
    clear_pass();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; centroid writes wait for the block to idle
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed_rows[i].op == ROW_CFG) begin
        drain();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_pixel(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].label);
      end
    end

    // Random passes, each under a different centroid setting
    for (int ph = 0; ph < RANDOM_PASSES; ph++) begin
      drain();
      idle_on <= !(ph == 2 || ph == 5);
      case (ph)
        0: for (int j = 0; j < NUM_REGS; j++) write_reg(3'(j), 24'($urandom));
        1: begin
          // Identical centroids: every pixel ties
          v = 24'($urandom);
          for (int j = 0; j < NUM_REGS; j++) write_reg(3'(j), v);
        end
        3: for (int j = 0; j < NUM_REGS; j++) write_reg(3'(j), j[0] ? 24'hFFFFFF : 24'h0);
        default: begin
          // Partial update, any index; otherwise iterate from the written-back means
          if ($urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 4)) write_reg(3'($urandom_range(0, 7)), 24'($urandom));
        end
      endcase
      // Stall the sink for a long stretch while pixels keep coming
      if (ph == 2) holdoff_req <= holdoff_req + 1;
      n = (ph == 2) ? 20 : $urandom_range(1, 20);
      for (int k = 0; k < n; k++) begin
        if (k > 0 && $urandom_range(0, 11) == 0) drain();
        if ($urandom_range(0, 1) == 0) begin
          v   = ctr_rgb[$urandom_range(0, CLUSTERS - 1)];
          rgb = {jitter(v[23:16]), jitter(v[15:8]), jitter(v[7:0])};
        end else begin
          rgb = 24'($urandom);
        end
        send_pixel(rgb, k == n - 1, NO_LABEL);
      end
    end

    // Closing pass with all centroids equal: cluster 0 takes every pixel
    // and the other clusters report empty
    drain();
    idle_on <= 1'b0;
    v = 24'($urandom);
    for (int j = 0; j < NUM_REGS; j++) write_reg(3'(j), v);
    for (int k = 0; k < CLOSE_PASS; k++) send_pixel(24'($urandom), k == CLOSE_PASS - 1, NO_LABEL);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
